@@ rtl/bndd_pkg.sv @@
package bndd_pkg;

	// field widths
	localparam int WB_W       = 8;
	localparam int ACT_W      = 16;
	localparam int SCALE_W    = 16;
	localparam int ZP_W       = 8;
	localparam int BLEN_W     = 11;
	localparam int RLEN_W     = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	// datapath widths: (q - zp) is 9b signed, times Q2.14 scale, times Q4.12 act
	localparam int DIFF_W = 9;
	localparam int PROD_W = DIFF_W + SCALE_W;
	localparam int TERM_W = PROD_W + ACT_W;
	localparam int SUM_W  = 56;

	// symmetric zero points
	localparam logic [ZP_W-1:0] ZP_SYM_NIB  = 8'd8;
	localparam logic [ZP_W-1:0] ZP_SYM_BYTE = 8'd128;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHT_BITS_EIGHT = 2'd0,
		CFG_SYMMETRIC_MODE    = 2'd1,
		CFG_BLOCK_LENGTH      = 2'd2,
		CFG_ROW_LENGTH        = 2'd3
	} cfg_reg_t;

	// per-item control that rides along the pipeline
	typedef struct packed {
		logic lane1_on;
		logic row_end;
	} item_ctl_t;

endpackage

@@ rtl/blockwise_nbit_dequant_dot.sv @@
// Blockwise 4/8-bit dequantize and dot product, one output of a quantized matmul.
// Input channel (in_valid/in_stall): one packed weight byte per item with its
// activations, block scale and zero-point byte; scale and zero point are taken
// from the first item of each quantization block. Two lanes handle the low and
// high nibble (only the low lane in 8-bit mode); a merging stage adds both lane
// terms into the 56-bit accumulator.
// Output channel (out_valid/out_stall): one dot_sum item per finished row.
// Throughput: one item per cycle unless a stall holds the pipeline. A row's sum
// passes the decoded item register, scale multiply, activation multiply and the
// accumulate into the output register. Config port (cfg_we/cfg_index/cfg_data)
// writes registers; the user must write them only while idle, which the block
// does not enforce. Reset: accumulator, positions and held scale/zero point
// clear; 4-bit asymmetric mode, block length 32, row length 4096. A stall on the
// output holds the result; items keep flowing until the next row end reaches
// the merging stage, then the pipeline backs up to in_stall.
module blockwise_nbit_dequant_dot #(
	parameter int MAX_ROW   = 4096,
	parameter int MAX_BLOCK = 1024
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [bndd_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [bndd_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [bndd_pkg::WB_W-1:0]               weight_byte,
	input  logic signed [bndd_pkg::ACT_W-1:0]       act_even,
	input  logic signed [bndd_pkg::ACT_W-1:0]       act_odd,
	input  logic signed [bndd_pkg::SCALE_W-1:0]     block_scale,
	input  logic [bndd_pkg::ZP_W-1:0]               zero_point_byte,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [bndd_pkg::SUM_W-1:0]       dot_sum
);
	import bndd_pkg::*;

	logic                       wb_eight_q, sym_q;
	logic [BLEN_W-1:0]          blen_q;
	logic [RLEN_W-1:0]          rlen_q;

	logic                       accept;
	logic signed [DIFF_W-1:0]   diff0, diff1;
	logic signed [SCALE_W-1:0]  scale;
	item_ctl_t                  ctl;

	logic                       v_s1, v_s2, v_s3;
	logic                       end_s1, end_s2, end_s3;
	logic signed [DIFF_W-1:0]   diff0_s1, diff1_s1;
	logic signed [SCALE_W-1:0]  scale_s1;
	logic signed [ACT_W-1:0]    act0_s1, act1_s1;
	logic signed [TERM_W-1:0]   term0, term1;
	logic signed [SUM_W-1:0]    acc_q, sum;
	logic signed [SUM_W-1:0]    dot_sum_q;
	logic                       out_valid_q;
	logic                       out_free, mv3, free3, free2, free1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_eight_q <= 1'b0;
			sym_q      <= 1'b0;
			blen_q     <= BLEN_W'(32);
			rlen_q     <= RLEN_W'(4096);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WEIGHT_BITS_EIGHT: wb_eight_q <= cfg_data[0];
				CFG_SYMMETRIC_MODE:    sym_q      <= cfg_data[0];
				CFG_BLOCK_LENGTH:      blen_q     <= cfg_data[BLEN_W-1:0];
				CFG_ROW_LENGTH:        rlen_q     <= cfg_data[RLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow: a stage moves when the one after it is free
	assign out_free = !out_valid_q || !out_stall;
	assign mv3      = v_s3 && (!end_s3 || out_free);
	assign free3    = !v_s3 || mv3;
	assign free2    = !v_s2 || free3;
	assign free1    = !v_s1 || free2;
	assign in_stall = !free1;
	assign accept   = in_valid && free1;

	bndd_ctrl #(
		.MAX_ROW   (MAX_ROW),
		.MAX_BLOCK (MAX_BLOCK)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.weight_bits_eight (wb_eight_q),
		.symmetric_mode    (sym_q),
		.block_length      (blen_q),
		.row_length        (rlen_q),
		.weight_byte       (weight_byte),
		.block_scale       (block_scale),
		.zero_point_byte   (zero_point_byte),
		.diff0             (diff0),
		.diff1             (diff1),
		.scale             (scale),
		.ctl               (ctl)
	);

	// decoded item register
	always_ff @(posedge clk) begin
		if (free1) begin
			diff0_s1 <= diff0;
			diff1_s1 <= diff1;
			scale_s1 <= scale;
			act0_s1  <= act_even;
			act1_s1  <= act_odd;
		end
	end

	// stage valids and row-end flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			end_s1 <= 1'b0;
			end_s2 <= 1'b0;
			end_s3 <= 1'b0;
		end else begin
			if (free1) begin
				v_s1   <= accept;
				end_s1 <= ctl.row_end;
			end
			if (free2) begin
				v_s2   <= v_s1;
				end_s2 <= end_s1;
			end
			if (free3) begin
				v_s3   <= v_s2;
				end_s3 <= end_s2;
			end
		end
	end

	// even and odd weight lanes
	bndd_lane u_lane0 (
		.clk     (clk),
		.load_s2 (free2),
		.load_s3 (free3),
		.diff    (diff0_s1),
		.scale   (scale_s1),
		.act     (act0_s1),
		.term    (term0)
	);

	bndd_lane u_lane1 (
		.clk     (clk),
		.load_s2 (free2),
		.load_s3 (free3),
		.diff    (diff1_s1),
		.scale   (scale_s1),
		.act     (act1_s1),
		.term    (term1)
	);

	// merge lanes into the accumulator; row end moves it to the output
	assign sum = acc_q + SUM_W'(term0) + SUM_W'(term1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mv3) acc_q <= end_s3 ? '0 : sum;
			if (mv3 && end_s3) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv3 && end_s3) dot_sum_q <= sum;
	end

	assign out_valid = out_valid_q;
	assign dot_sum   = dot_sum_q;

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mv3 && end_s3) |=> (acc_q == '0))
		else $error("accumulator not cleared at row end");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with empty decode stage");

	a_out_from_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s3 && end_s3))
		else $error("result without row end");

endmodule

@@ rtl/bndd_ctrl.sv @@
module bndd_ctrl #(
	parameter int MAX_ROW   = 4096,
	parameter int MAX_BLOCK = 1024
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  logic                                    weight_bits_eight,
	input  logic                                    symmetric_mode,
	input  logic [bndd_pkg::BLEN_W-1:0]             block_length,
	input  logic [bndd_pkg::RLEN_W-1:0]             row_length,
	input  logic [bndd_pkg::WB_W-1:0]               weight_byte,
	input  logic signed [bndd_pkg::SCALE_W-1:0]     block_scale,
	input  logic [bndd_pkg::ZP_W-1:0]               zero_point_byte,
	output logic signed [bndd_pkg::DIFF_W-1:0]      diff0,
	output logic signed [bndd_pkg::DIFF_W-1:0]      diff1,
	output logic signed [bndd_pkg::SCALE_W-1:0]     scale,
	output bndd_pkg::item_ctl_t                     ctl
);
	import bndd_pkg::*;

	localparam int RPW = $clog2(MAX_ROW + 1);
	localparam int BPW = $clog2(MAX_BLOCK + 1);
	localparam int RCW = (RPW > RLEN_W) ? RPW : RLEN_W;
	localparam int BCW = (BPW > BLEN_W) ? BPW : BLEN_W;
	localparam logic [RCW-1:0] MAX_ROW_C = RCW'(MAX_ROW);
	localparam logic [BCW-1:0] MAX_BLK_C = BCW'(MAX_BLOCK);

	logic [RPW-1:0]              row_pos_q, row_p1, row_p2, row_pos_d;
	logic [BPW-1:0]              blk_pos_q, blk_p1, blk_p2, blk_pos_d;
	logic                        parity_q, parity_d;
	logic signed [SCALE_W-1:0]   held_scale_q;
	logic [ZP_W-1:0]             held_zp_q;
	logic [RCW-1:0]              rlen_x, eff_row;
	logic [BCW-1:0]              blen_x, eff_blk;
	logic                        blk_start;
	logic                        blk_close0, row_close0, blk_close1, row_close1;
	logic [ZP_W-1:0]             zp_byte, zp;
	logic [ZP_W-1:0]             q0, q1;

	// effective lengths: zero acts as one, clamp at the maximum
	always_comb begin
		rlen_x = RCW'(row_length);
		blen_x = BCW'(block_length);
		if (rlen_x == '0) eff_row = RCW'(1);
		else if (rlen_x > MAX_ROW_C) eff_row = MAX_ROW_C;
		else eff_row = rlen_x;
		if (blen_x == '0) eff_blk = BCW'(1);
		else if (blen_x > MAX_BLK_C) eff_blk = MAX_BLK_C;
		else eff_blk = blen_x;
	end

	// position lookahead for both lanes
	assign row_p1     = row_pos_q + RPW'(1);
	assign row_p2     = row_pos_q + RPW'(2);
	assign blk_p1     = blk_pos_q + BPW'(1);
	assign blk_p2     = blk_pos_q + BPW'(2);
	assign blk_close0 = BCW'(blk_p1) >= eff_blk;
	assign row_close0 = RCW'(row_p1) >= eff_row;
	assign blk_close1 = BCW'(blk_p2) >= eff_blk;
	assign row_close1 = RCW'(row_p2) >= eff_row;
	assign blk_start  = (blk_pos_q == '0);

	// second nibble only if the first one left its block and row open
	assign ctl.lane1_on = !weight_bits_eight && !blk_close0 && !row_close0;
	assign ctl.row_end  = row_close0 || (ctl.lane1_on && row_close1);

	// zero point and scale, taken fresh at block start
	always_comb begin
		zp_byte = blk_start ? zero_point_byte : held_zp_q;
		if (symmetric_mode) zp = weight_bits_eight ? ZP_SYM_BYTE : ZP_SYM_NIB;
		else if (weight_bits_eight) zp = zp_byte;
		else if (parity_q) zp = {4'd0, zp_byte[7:4]};
		else zp = {4'd0, zp_byte[3:0]};
	end
	assign scale = blk_start ? block_scale : held_scale_q;

	// weight codes minus zero point; idle second lane gives zero
	assign q0    = weight_bits_eight ? weight_byte : {4'd0, weight_byte[3:0]};
	assign q1    = {4'd0, weight_byte[7:4]};
	assign diff0 = $signed({1'b0, q0}) - $signed({1'b0, zp});
	assign diff1 = ctl.lane1_on ? ($signed({1'b0, q1}) - $signed({1'b0, zp})) : '0;

	// next row/block position
	always_comb begin
		row_pos_d = row_p1;
		blk_pos_d = blk_p1;
		parity_d  = parity_q;
		if (ctl.lane1_on) begin
			row_pos_d = row_p2;
			blk_pos_d = blk_p2;
			if (blk_close1) begin
				blk_pos_d = '0;
				parity_d  = !parity_q;
			end
		end else if (blk_close0) begin
			blk_pos_d = '0;
			parity_d  = !parity_q;
		end
		if (ctl.row_end) begin
			row_pos_d = '0;
			blk_pos_d = '0;
			parity_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q    <= '0;
			blk_pos_q    <= '0;
			parity_q     <= 1'b0;
			held_scale_q <= '0;
			held_zp_q    <= '0;
		end else if (accept) begin
			row_pos_q <= row_pos_d;
			blk_pos_q <= blk_pos_d;
			parity_q  <= parity_d;
			if (blk_start) begin
				held_scale_q <= block_scale;
				held_zp_q    <= zero_point_byte;
			end
		end
	end

	// positions never reach their maximum
	a_row_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_pos_q < RPW'(MAX_ROW))
		else $error("row position out of range");

	a_blk_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		blk_pos_q < BPW'(MAX_BLOCK))
		else $error("block position out of range");

	a_row_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctl.row_end) |=> (row_pos_q == '0 && blk_pos_q == '0 && !parity_q))
		else $error("row end did not clear positions");

endmodule

@@ rtl/bndd_lane.sv @@
module bndd_lane (
	input  logic                                 clk,
	input  logic                                 load_s2,
	input  logic                                 load_s3,
	input  logic signed [bndd_pkg::DIFF_W-1:0]   diff,
	input  logic signed [bndd_pkg::SCALE_W-1:0]  scale,
	input  logic signed [bndd_pkg::ACT_W-1:0]    act,
	output logic signed [bndd_pkg::TERM_W-1:0]   term
);
	import bndd_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACT_W-1:0]  act_s2;
	logic signed [TERM_W-1:0] term_s3;

	// (q - zp) * scale, then times activation
	always_ff @(posedge clk) begin
		if (load_s2) begin
			prod_s2 <= diff * scale;
			act_s2  <= act;
		end
		if (load_s3) begin
			term_s3 <= prod_s2 * act_s2;
		end
	end

	assign term = term_s3;

endmodule
